/* hw/rtl/pidc_pkg.sv */
// Shared types and constants for the clamped PID controller.
// No dependencies; compiled first.
package pidc_pkg;

  localparam int unsigned DataW = 16;
  localparam int unsigned GainW = 16;
  localparam int unsigned ModeW = 2;
  localparam int unsigned IdxW  = 3;

  typedef logic signed [DataW-1:0] pidc_data_t;
  typedef logic        [GainW-1:0] pidc_gain_t;
  typedef logic        [IdxW-1:0]  pidc_idx_t;

  // Request modes; the fourth code holds state and returns the integral.
  typedef enum logic [ModeW-1:0] {
    MODE_COMPUTE = 2'd0,
    MODE_CLEAR   = 2'd1,
    MODE_PRELOAD = 2'd2
  } pidc_mode_e;

  // Configuration register map.
  typedef enum logic [IdxW-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INT_GAIN   = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_OUT_LOW    = 3'd3,
    REG_OUT_HIGH   = 3'd4,
    REG_REVERSE    = 3'd5
  } pidc_reg_e;

  localparam pidc_data_t OutLowRst  = 16'sh8000;
  localparam pidc_data_t OutHighRst = 16'sh7FFF;

endpackage

/* hw/rtl/pidc_if.sv */
// Handshake channel interfaces of the clamped PID controller.
// Depends on pidc_pkg.
interface pidc_req_if;
  logic                  valid;
  logic                  ready;
  logic [pidc_pkg::ModeW-1:0] mode;
  pidc_pkg::pidc_data_t  measurement;
  pidc_pkg::pidc_data_t  setpoint;
  pidc_pkg::pidc_data_t  preload;

  modport source (output valid, mode, measurement, setpoint, preload, input ready);
  modport sink   (input valid, mode, measurement, setpoint, preload, output ready);
endinterface

interface pidc_rsp_if;
  logic                 valid;
  logic                 ready;
  pidc_pkg::pidc_data_t drive;

  modport source (output valid, drive, input ready);
  modport sink   (input valid, drive, output ready);
endinterface

interface pidc_cfg_if;
  logic                 valid;
  logic                 ready;
  pidc_pkg::pidc_idx_t  index;
  logic [pidc_pkg::DataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/pid_controller_clamped_unit.sv */
// Clamped PID controller (derivative on measurement, anti-windup clamp).
// Depends on pidc_pkg and the channel interfaces in pidc_if.sv.
//
// Usage:
//   req_i  - one request per sample: mode, measurement, setpoint, preload.
//   rsp_o  - one response per request carrying the 16-bit drive.
//   cfg_i  - register writes (gains, limits, reverse); always ready, and
//            meant to be used only while the block is idle.
// Path: an accepted request is held in the request register, then loaded
//   into the response register that drives rsp_o (two register stages).
// Throughput: one request per cycle while responses are taken. The integral
//   and last measurement are updated in the same cycle as the response
//   register is loaded, so back-to-back requests see the updated state.
// Stall: when rsp_o is not taken, the response holds, the request register
//   fills, and req_i.ready drops only once both stages are occupied.
// Reset: both stages empty, integral and last measurement zero, gains
//   zero, limits at the full signed 16-bit range, direct action.
module pid_controller_clamped_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  pidc_req_if.sink   req_i,
  pidc_rsp_if.source rsp_o,
  pidc_cfg_if.sink   cfg_i
);
  import pidc_pkg::*;

  // Configuration registers
  pidc_gain_t prop_q, int_q, deriv_q;
  pidc_data_t out_low_q, out_high_q;
  logic       reverse_q;

  // Request register
  logic             s1_valid_q;
  logic [ModeW-1:0] s1_mode_q;
  pidc_data_t       s1_meas_q, s1_sp_q, s1_pre_q;

  // Response register and controller state
  logic       out_valid_q;
  pidc_data_t drive_q, drive_d;
  pidc_data_t integ_q, integ_d;
  pidc_data_t last_q, last_d;

  logic s1_adv;
  logic req_acc;

  // Datapath
  logic signed [16:0] err, dmeas;
  logic signed [33:0] p_prod, i_prod, d_prod;
  logic signed [35:0] pd_sum, i_sum;
  logic signed [27:0] pd_rnd, i_rnd;
  logic signed [28:0] integ_wide, drive_wide;
  pidc_data_t         integ_cmp, pre_clamped;

  // Clamp order: above high gives high, otherwise below low gives low.
  function automatic pidc_data_t clamp_lim(input logic signed [28:0] v,
                                           input pidc_data_t lo,
                                           input pidc_data_t hi);
    pidc_data_t r;
    if (v > 29'(hi)) begin
      r = hi;
    end else if (v < 29'(lo)) begin
      r = lo;
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- config
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_q     <= '0;
      int_q      <= '0;
      deriv_q    <= '0;
      out_low_q  <= OutLowRst;
      out_high_q <= OutHighRst;
      reverse_q  <= 1'b0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (pidc_reg_e'(cfg_i.index))
        REG_PROP_GAIN:  prop_q     <= cfg_i.data;
        REG_INT_GAIN:   int_q      <= cfg_i.data;
        REG_DERIV_GAIN: deriv_q    <= cfg_i.data;
        REG_OUT_LOW:    out_low_q  <= $signed(cfg_i.data);
        REG_OUT_HIGH:   out_high_q <= $signed(cfg_i.data);
        REG_REVERSE:    reverse_q  <= cfg_i.data[0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // ------------------------------------------------------------ handshake
  // Stage 1 moves on when the response slot is free or being emptied.
  assign s1_adv      = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign req_acc     = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      s1_mode_q <= req_i.mode;
      s1_meas_q <= req_i.measurement;
      s1_sp_q   <= req_i.setpoint;
      s1_pre_q  <= req_i.preload;
    end
  end

  // -------------------------------------------------------------- datapath
  assign err   = 17'(s1_sp_q) - 17'(s1_meas_q);
  assign dmeas = 17'(s1_meas_q) - 17'(last_q);

  assign p_prod = $signed({1'b0, prop_q})  * err;
  assign i_prod = $signed({1'b0, int_q})   * err;
  assign d_prod = $signed({1'b0, deriv_q}) * dmeas;

  // Reverse action negates the products before rounding.
  always_comb begin
    pd_sum = 36'(p_prod) - 36'(d_prod);
    i_sum  = 36'(i_prod);
    if (reverse_q) begin
      pd_sum = -pd_sum;
      i_sum  = -i_sum;
    end
  end

  // Round to nearest, ties toward plus infinity: floor((x + 128) / 256).
  logic signed [35:0] pd_bias, i_bias;
  assign pd_bias = pd_sum + 36'sd128;
  assign i_bias  = i_sum + 36'sd128;
  assign pd_rnd  = pd_bias[35:8];
  assign i_rnd   = i_bias[35:8];

  assign integ_wide  = 29'(i_rnd) + 29'(integ_q);
  assign integ_cmp   = clamp_lim(integ_wide, out_low_q, out_high_q);
  assign drive_wide  = 29'(pd_rnd) + 29'(integ_cmp);
  assign pre_clamped = clamp_lim(29'(s1_pre_q), out_low_q, out_high_q);

  always_comb begin
    integ_d = integ_q;
    last_d  = last_q;
    drive_d = integ_q;
    unique case (pidc_mode_e'(s1_mode_q))
      MODE_COMPUTE: begin
        integ_d = integ_cmp;
        last_d  = s1_meas_q;
        drive_d = clamp_lim(drive_wide, out_low_q, out_high_q);
      end
      MODE_CLEAR: begin
        integ_d = '0;
        last_d  = '0;
        drive_d = '0;
      end
      MODE_PRELOAD: begin
        integ_d = pre_clamped;
        last_d  = s1_meas_q;
        drive_d = pre_clamped;
      end
      default: ;  // spare code: state held, drive shows the integral
    endcase
  end

  // --------------------------------------------------- state and response
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q     <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        integ_q     <= integ_d;
        last_q      <= last_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      drive_q <= drive_d;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.drive = drive_q;

  // ------------------------------------------------------------ assertions
  // A held response must keep the pending request in stage 1.
  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !rsp_o.ready) |=> s1_valid_q)
    else $error("pending request lost while response stalled");

  // Back-pressure only when stage 1 is occupied.
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (s1_valid_q && out_valid_q))
    else $error("request port stalled with a free slot");

  // A clear leaves zeroed state and a zero response.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_mode_q == MODE_CLEAR) |=>
      (integ_q == '0 && last_q == '0 && rsp_o.drive == '0 && rsp_o.valid))
    else $error("clear did not zero the state");

  // With ordered limits, a compute leaves the integral inside them.
  a_integ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_mode_q == MODE_COMPUTE && out_low_q <= out_high_q) |=>
      (integ_q >= $past(out_low_q) && integ_q <= $past(out_high_q)))
    else $error("integral escaped its limits");

endmodule
